// ===== hdl/matrix3_inverse_unit_assert.svh =====
// Assertion macros for the 3x3 matrix inverse unit
`ifndef MATRIX3_INVERSE_UNIT_ASSERT_SVH
`define MATRIX3_INVERSE_UNIT_ASSERT_SVH
// implication check under reset
`define M3I_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("m3i check failed");
// next-cycle check under reset
`define M3I_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("m3i check failed");
`endif

// ===== hdl/m3i_pkg.sv =====
// Shared types and constants for the 3x3 matrix inverse unit
`timescale 1ns / 1ps
package m3i_pkg;
  localparam int FracBits = 16;
  localparam int ElemW = 32;
  localparam int AdjW = 66;
  localparam int DetW = 100;
  localparam int NumW = AdjW + 2 * FracBits + 1;
  localparam int QW = 34;
  localparam int Lanes = 9;
  localparam int DivStages = QW;
  localparam int FrontStages = 6;
  localparam int LatTot = FrontStages + DivStages + 2;
  localparam int ThrW = 31;
  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [AdjW-1:0] adj_t;
  typedef logic signed [DetW-1:0] det_t;
endpackage

// ===== hdl/m3i_div_lane.sv =====
// Pipelined restoring divider lane: rounded, signed, saturated quotient of one adjugate entry
`timescale 1ns / 1ps
module m3i_div_lane (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [m3i_pkg::AdjW-1:0] adj_i,
  input  logic [m3i_pkg::DetW-1:0]     dmag_i,
  input  logic                         dneg_i,
  output logic signed [m3i_pkg::ElemW-1:0] q_o
);
  localparam int AW = m3i_pkg::AdjW;
  localparam int NW = m3i_pkg::NumW;
  localparam int DW = m3i_pkg::DetW;
  localparam int S = m3i_pkg::DivStages;
  localparam int RW = DW + 2;
  logic [NW-1:0] num_q [S];
  logic [RW-1:0] rem_q [S];
  logic [DW:0]   d2_q  [S];
  logic [S-1:0]  qb_q  [S+1];
  logic          neg_q [S+1];
  logic          ovf_q [S+1];
  logic [AW-1:0] amag;
  logic [NW-1:0] num0;
  logic [NW:0]   hi0;
  logic [DW+1:0] d2x;
  logic          ovf0;
  logic [S:0]    qfull;
  logic signed [m3i_pkg::ElemW-1:0] q_d, q_q;

  always_comb begin
    amag = adj_i[AW-1] ? AW'(-adj_i) : AW'(adj_i);
    num0 = (NW'(amag) << (2 * m3i_pkg::FracBits + 1)) + NW'(dmag_i);
    hi0  = {1'b0, num0} >> S;
    d2x  = {1'b0, dmag_i, 1'b0};
    ovf0 = ((DW + 2)'(hi0) >= d2x);
  end

  // stage 0 holds prepared numerator; remainder starts from top bits beyond quotient width
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= num0;
      d2_q[0]  <= {dmag_i, 1'b0};
      neg_q[0] <= adj_i[AW-1] ^ dneg_i;
      ovf_q[0] <= ovf0;
      rem_q[0] <= RW'(hi0);
      qb_q[0]  <= '0;
    end
  end

  for (genvar s = 0; s < S; s++) begin : g_stage
    logic [RW-1:0] r_sh;
    logic          ge;
    always_comb begin
      r_sh = {rem_q[s][RW-2:0], num_q[s][S-1-s]};
      ge   = r_sh >= RW'(d2_q[s]);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[s+1] <= neg_q[s];
        ovf_q[s+1] <= ovf_q[s];
        qb_q[s+1]  <= {qb_q[s][S-2:0], ge};
      end
    end
    if (s < S - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          num_q[s+1] <= num_q[s];
          d2_q[s+1]  <= d2_q[s];
          rem_q[s+1] <= ge ? r_sh - RW'(d2_q[s]) : r_sh;
        end
      end
    end
  end

  always_comb begin
    qfull = {1'b0, qb_q[S]};
    if (!neg_q[S]) begin
      if (ovf_q[S] || qfull > 35'h07FFFFFFF) q_d = 32'sh7FFFFFFF;
      else q_d = m3i_pkg::ElemW'(qfull);
    end else begin
      if (ovf_q[S] || qfull > 35'h080000000) q_d = 32'sh80000000;
      else q_d = m3i_pkg::ElemW'(-qfull);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) q_q <= q_d;
  end
  assign q_o = q_q;
endmodule

// ===== hdl/m3i_front.sv =====
// Front end: minors, adjugate, determinant and its magnitude, six registered stages
`timescale 1ns / 1ps
module m3i_front (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [9*m3i_pkg::ElemW-1:0]   m_i,
  output logic [9*m3i_pkg::AdjW-1:0]    adj_o,
  output logic [m3i_pkg::DetW-1:0]      dmag_o,
  output logic                          dneg_o
);
  localparam int EW = m3i_pkg::ElemW;
  localparam int AW = m3i_pkg::AdjW;
  localparam int DW = m3i_pkg::DetW;
  localparam int SplitW = 33;
  localparam int PW = EW + SplitW + 1;
  localparam int HW = EW + AW - SplitW;
  logic signed [EW-1:0] m [9];
  logic signed [63:0] p_q [18];
  logic signed [EW-1:0] m1_q [3];
  logic signed [AW-1:0] adj_q [9];
  logic signed [EW-1:0] m2_q [3];
  logic signed [PW-1:0] pl_q [3];
  logic signed [HW-1:0] ph_q [3];
  logic signed [AW-1:0] adj2_q [9];
  logic signed [DW-1:0] t_q [3];
  logic signed [AW-1:0] adj3_q [9];
  logic signed [DW-1:0] det_q;
  logic signed [AW-1:0] adj4_q [9];
  logic [9*AW-1:0] adj5_q;
  logic [DW-1:0] dmag_q;
  logic dneg_q;

  for (genvar i = 0; i < 9; i++) begin : g_unpack
    assign m[i] = m_i[i*EW +: EW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0]  <= m[4] * m[8]; p_q[1]  <= m[5] * m[7];
      p_q[2]  <= m[1] * m[8]; p_q[3]  <= m[2] * m[7];
      p_q[4]  <= m[1] * m[5]; p_q[5]  <= m[2] * m[4];
      p_q[6]  <= m[3] * m[8]; p_q[7]  <= m[5] * m[6];
      p_q[8]  <= m[0] * m[8]; p_q[9]  <= m[2] * m[6];
      p_q[10] <= m[0] * m[5]; p_q[11] <= m[2] * m[3];
      p_q[12] <= m[3] * m[7]; p_q[13] <= m[4] * m[6];
      p_q[14] <= m[0] * m[7]; p_q[15] <= m[1] * m[6];
      p_q[16] <= m[0] * m[4]; p_q[17] <= m[1] * m[3];
      m1_q[0] <= m[0]; m1_q[1] <= m[1]; m1_q[2] <= m[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        if (k % 2 == 0) adj_q[k] <= AW'(p_q[2*k]) - AW'(p_q[2*k+1]);
        else            adj_q[k] <= AW'(p_q[2*k+1]) - AW'(p_q[2*k]);
      end
      m2_q <= m1_q;
    end
  end

  // split each cofactor into a signed high half and an unsigned low half
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        pl_q[j] <= m2_q[j] * signed'({1'b0, adj_q[3*j][SplitW-1:0]});
        ph_q[j] <= m2_q[j] * signed'(adj_q[3*j][AW-1:SplitW]);
      end
      adj2_q <= adj_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) t_q[j] <= (DW'(ph_q[j]) <<< SplitW) + DW'(pl_q[j]);
      adj3_q <= adj2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q <= t_q[0] + t_q[1] + t_q[2];
      adj4_q <= adj3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dneg_q <= det_q[DW-1];
      dmag_q <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
      for (int k = 0; k < 9; k++) adj5_q[k*AW +: AW] <= adj4_q[k];
    end
  end

  assign adj_o  = adj5_q;
  assign dmag_o = dmag_q;
  assign dneg_o = dneg_q;
endmodule

// ===== hdl/matrix3_inverse_unit.sv =====
// 3x3 matrix inverse unit: top level with lanes, merge stage and output register
// Takes one Q16.16 3x3 matrix per item and accepts a new item every cycle in which the
// output side is free. Each item passes through six front stages (products, adjugate,
// split determinant products, their sums, determinant, its magnitude), one prepare stage
// and a 34-stage quotient pipeline in each of nine lanes, the lane output register and
// one merge stage. A determinant that is zero or whose rounded magnitude is below the
// threshold written through cfg_wdata_i yields the identity with tuser set. A stall on the
// output side freezes the whole pipeline and holds s_axis_tready low.
`timescale 1ns / 1ps
`include "matrix3_inverse_unit_assert.svh"
module matrix3_inverse_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [30:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,  // a00,a01,a02,a10,a11,a12,a20,a21,a22
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [287:0] m_axis_tdata,  // inv00,...,inv22
  output logic         m_axis_tuser   // singular
);
  localparam int EW = m3i_pkg::ElemW;
  localparam int AW = m3i_pkg::AdjW;
  localparam int DW = m3i_pkg::DetW;
  localparam int L = m3i_pkg::LatTot;
  localparam int SL = m3i_pkg::DivStages + 2;
  localparam int FB = m3i_pkg::FracBits;
  logic [m3i_pkg::ThrW-1:0] thr_q;
  logic [L-1:0] vld_q;
  logic en;
  logic [9*AW-1:0] adj;
  logic [DW-1:0] dmag;
  logic dneg;
  logic [DW-1:0] rmag;
  logic sing_d;
  logic [SL-1:0] sing_q;
  logic [EW-1:0] q [9];
  logic [287:0] data_q;
  logic tuser_q, ovld_q;

  assign en = !ovld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= 31'd1;
    else if (cfg_we_i) thr_q <= cfg_wdata_i;
  end

  m3i_front u_front (
    .clk_i, .en_i(en), .m_i(s_axis_tdata), .adj_o(adj), .dmag_o(dmag), .dneg_o(dneg));

  always_comb begin
    rmag = (dmag + (DW'(1) << (2*FB-1))) >> (2*FB);
    sing_d = (dmag == '0) || (rmag < DW'(thr_q));
  end

  for (genvar i = 0; i < 9; i++) begin : g_lane
    m3i_div_lane u_lane (
      .clk_i, .en_i(en), .adj_i(adj[i*AW +: AW]), .dmag_i(dmag),
      .dneg_i(dneg), .q_o(q[i]));
  end

  // singular flag follows the lanes; shift register of matching depth
  always_ff @(posedge clk_i) begin
    if (en) sing_q <= {sing_q[SL-2:0], sing_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[L-2:0], s_axis_tvalid};
  end

  // merge: pick lane quotients or identity
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        if (sing_q[SL-1]) data_q[k*EW +: EW] <= (k % 4 == 0) ? EW'(1) << FB : '0;
        else data_q[k*EW +: EW] <= q[k];
      end
      tuser_q <= sing_q[SL-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovld_q <= 1'b0;
    else if (en) ovld_q <= vld_q[L-1];
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = tuser_q;

  `M3I_ASSERT_IMP(a_ready_free, !m_axis_tvalid, s_axis_tready)
  `M3I_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `M3I_ASSERT_IMP(a_ident, m_axis_tvalid && m_axis_tuser, m_axis_tdata[31:0] == 32'h00010000)
endmodule

// ===== tb/matrix3_inverse_unit_tb.sv =====
// Self-checking testbench for the 3x3 matrix inverse unit
`timescale 1ns / 1ps
module matrix3_inverse_unit_tb;

  localparam int NumRandom = 1600;
  localparam int CalmItems = 200;
  localparam int HoldCycles = 300;
  localparam int IdleLimit = 20000;
  localparam logic [31:0] QOne = 32'h0001_0000;

  typedef struct {
    logic [287:0] mat;
    logic         sing;
  } inverse_t;

  typedef struct {
    logic [287:0] mat;
    logic         known;
    inverse_t     res;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [30:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;  // a00,a01,a02,a10,a11,a12,a20,a21,a22
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [287:0] m_axis_tdata;       // inv00,...,inv22
  logic         m_axis_tuser;       // singular

  inverse_t     pending_inverses[$];
  logic [30:0]  threshold = 31'd1;
  logic         calm = 1'b0;
  logic         hold_req = 1'b0;
  logic         cur_known = 1'b0;
  inverse_t     cur_typed;
  int           fail_count = 0;
  int           idle_cycles = 0;

  matrix3_inverse_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  function automatic m3i_pkg::adj_t minor_q(logic signed [63:0] x, logic signed [63:0] y,
                                            logic signed [63:0] u, logic signed [63:0] v);
    m3i_pkg::adj_t p, q;
    p = m3i_pkg::adj_t'(x * y);
    q = m3i_pkg::adj_t'(u * v);
    return p - q;
  endfunction

  function automatic logic [127:0] det_mag(m3i_pkg::det_t d);
    m3i_pkg::det_t m;
    m = (d < 0) ? -d : d;
    return {28'b0, m};
  endfunction

  function automatic inverse_t invert_q16(logic [287:0] mtx, logic [30:0] thr);
    logic signed [63:0] e[9];
    m3i_pkg::adj_t      adj[9];
    m3i_pkg::adj_t      am;
    m3i_pkg::det_t      det;
    logic [127:0]       dmag, amag, q, rounded;
    logic               neg;
    inverse_t           r;
    for (int i = 0; i < 9; i++) e[i] = signed'(mtx[32*i +: 32]);
    adj[0] = minor_q(e[4], e[8], e[5], e[7]);
    adj[1] = -minor_q(e[1], e[8], e[2], e[7]);
    adj[2] = minor_q(e[1], e[5], e[2], e[4]);
    adj[3] = -minor_q(e[3], e[8], e[5], e[6]);
    adj[4] = minor_q(e[0], e[8], e[2], e[6]);
    adj[5] = -minor_q(e[0], e[5], e[2], e[3]);
    adj[6] = minor_q(e[3], e[7], e[4], e[6]);
    adj[7] = -minor_q(e[0], e[7], e[1], e[6]);
    adj[8] = minor_q(e[0], e[4], e[1], e[3]);
    det = m3i_pkg::det_t'(e[0]) * m3i_pkg::det_t'(adj[0])
        + m3i_pkg::det_t'(e[1]) * m3i_pkg::det_t'(adj[3])
        + m3i_pkg::det_t'(e[2]) * m3i_pkg::det_t'(adj[6]);
    dmag = det_mag(det);
    rounded = (dmag + (128'd1 << 31)) >> 32;
    r.mat = '0;
    if (det == 0 || rounded < {97'b0, thr}) begin
      r.mat[0 +: 32] = QOne;
      r.mat[128 +: 32] = QOne;
      r.mat[256 +: 32] = QOne;
      r.sing = 1'b1;
      return r;
    end
    r.sing = 1'b0;
    for (int i = 0; i < 9; i++) begin
      am = (adj[i] < 0) ? -adj[i] : adj[i];
      amag = {62'b0, am};
      q = (((amag << 32) << 1) + dmag) / (dmag << 1);
      neg = (adj[i] < 0) != (det < 0);
      if (!neg) r.mat[32*i +: 32] = (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      else r.mat[32*i +: 32] = (q > 128'h8000_0000) ? 32'h8000_0000 : 32'(0 - q[31:0]);
    end
    return r;
  endfunction

  function automatic logic [287:0] diag_mtx(logic [31:0] d);
    logic [287:0] m;
    m = '0;
    m[0 +: 32] = d;
    m[128 +: 32] = d;
    m[256 +: 32] = d;
    return m;
  endfunction

  function automatic logic [287:0] fill_mtx(logic [31:0] v);
    return {9{v}};
  endfunction

  function automatic inverse_t ident_res(logic [31:0] d, logic s);
    inverse_t r;
    r.mat = diag_mtx(d);
    r.sing = s;
    return r;
  endfunction

  function automatic logic [31:0] rand_elem(int kind);
    case (kind)
      0: return $urandom;
      1: return 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return 32'(signed'($urandom_range(0, 512)) - 256);
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          3: return 32'hFFFF_FFFF;
          default: return QOne;
        endcase
      end
    endcase
  endfunction

  function automatic logic [287:0] rand_mtx();
    logic [287:0] m;
    int kind, sel;
    sel = $urandom_range(0, 9);
    kind = (sel < 5) ? 1 : (sel < 7) ? 0 : (sel < 8) ? 2 : 3;
    for (int i = 0; i < 9; i++) m[32*i +: 32] = rand_elem(kind);
    // near-singular: make one row the copy of another plus a small offset
    if ($urandom_range(0, 7) == 0) begin
      for (int c = 0; c < 3; c++)
        m[32*(6+c) +: 32] = m[32*c +: 32] + 32'($urandom_range(0, 3));
    end
    return m;
  endfunction

  task automatic send_item(logic [287:0] mtx, logic known, inverse_t typed);
    s_axis_tdata <= mtx;
    s_axis_tvalid <= 1'b1;
    cur_known <= known;
    cur_typed <= typed;
    do @(posedge clk_i); while (!s_axis_tready);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic drain_and_write(logic [30:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending_inverses.size() == 0);
    repeat (m3i_pkg::LatTot + 5) @(posedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    threshold = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // record expectations and check results
  always @(posedge clk_i) begin
    inverse_t exp_res;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        exp_res = invert_q16(s_axis_tdata, threshold);
        if (cur_known) exp_res = cur_typed;
        pending_inverses.push_back(exp_res);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_inverses.size() == 0) begin
          $display("%0t: unexpected result tdata=%h tuser=%b", $time, m_axis_tdata,
                   m_axis_tuser);
          fail_count++;
        end else begin
          exp_res = pending_inverses.pop_front();
          for (int i = 0; i < 9; i++)
            if (m_axis_tdata[32*i +: 32] !== exp_res.mat[32*i +: 32]) begin
              $display("%0t: inv%0d%0d expected %h actual %h", $time, i / 3, i % 3,
                       exp_res.mat[32*i +: 32], m_axis_tdata[32*i +: 32]);
              fail_count++;
            end
          if (m_axis_tuser !== exp_res.sing) begin
            $display("%0t: singular expected %b actual %b", $time, exp_res.sing,
                     m_axis_tuser);
            fail_count++;
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("matrix3_inverse_unit_tb: FAIL");
        $finish;
      end
    end
  end

  // output side: random stalls, one long hold on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
        if (!calm && !hold_req) begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(1, 17)) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    inverse_t  none;
    logic [30:0] thr_plan[4];
    none.mat = '0;
    none.sing = 1'b0;

    row.known = 1'b1;
    row.mat = '0;                       row.res = ident_res(QOne, 1'b1); rows.push_back(row);
    row.mat = diag_mtx(QOne);           row.res = ident_res(QOne, 1'b0); rows.push_back(row);
    row.mat = diag_mtx(32'h0002_0000);  row.res = ident_res(32'h0000_8000, 1'b0);
    rows.push_back(row);
    row.mat = diag_mtx(32'hFFFF_0000);  row.res = ident_res(32'hFFFF_0000, 1'b0);
    rows.push_back(row);
    row.mat = diag_mtx(32'h1);          row.res = ident_res(QOne, 1'b1); rows.push_back(row);
    row.mat = fill_mtx(32'h7FFF_FFFF);  row.res = ident_res(QOne, 1'b1); rows.push_back(row);
    row.mat = fill_mtx(32'h8000_0000);  row.res = ident_res(QOne, 1'b1); rows.push_back(row);
    row.known = 1'b0;
    row.res = none;
    row.mat = diag_mtx(32'h7FFF_FFFF);  rows.push_back(row);
    row.mat = diag_mtx(32'h8000_0000);  rows.push_back(row);
    row.mat = diag_mtx(32'h0000_8000);  rows.push_back(row);
    row.mat = diag_mtx(32'h0000_0100);  rows.push_back(row);
    row.mat = {32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
               32'h0, 32'h0003_0000, 32'h0};
    rows.push_back(row);
    row.mat = {32'h0002_0000, 32'hFFFF_0000, 32'h0, 32'hFFFF_0000, 32'h0002_0000,
               32'hFFFF_0000, 32'h0, 32'hFFFF_0000, 32'h0002_0000};
    rows.push_back(row);
    row.mat = {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h1, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
    rows.push_back(row);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_item(rows[i].mat, rows[i].known, rows[i].res);

    // threshold zero: tiny determinants pass, zero still singular
    drain_and_write(31'd0);
    send_item(diag_mtx(32'h1), 1'b0, none);
    send_item(diag_mtx(32'h100), 1'b0, none);
    send_item('0, 1'b1, ident_res(QOne, 1'b1));
    send_item(diag_mtx(32'h0000_8000), 1'b0, none);

    // largest threshold: the identity turns singular, very large determinants still pass
    drain_and_write(31'h7FFF_FFFF);
    send_item(diag_mtx(32'h7FFF_FFFF), 1'b0, none);
    send_item(diag_mtx(QOne), 1'b1, ident_res(QOne, 1'b1));
    send_item(diag_mtx(32'h8000_0000), 1'b0, none);

    thr_plan[0] = 31'd1;
    thr_plan[1] = 31'($urandom_range(2, 64));
    thr_plan[2] = 31'd0;
    thr_plan[3] = 31'd1;
    for (int p = 0; p < 4; p++) begin
      drain_and_write(thr_plan[p]);
      for (int n = 0; n < NumRandom / 4; n++) begin
        if (p == 1 && n == 20) hold_req = 1'b1;
        if (p == 3 && n == NumRandom / 4 - CalmItems) calm = 1'b1;
        send_item(rand_mtx(), 1'b0, none);
      end
      if (p == 0) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        wait (pending_inverses.size() == 0);
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    wait (pending_inverses.size() == 0);
    repeat (m3i_pkg::LatTot + 10) @(posedge clk_i);
    if (fail_count == 0 && pending_inverses.size() == 0) begin
      $display("matrix3_inverse_unit_tb: PASS");
    end else begin
      $display("matrix3_inverse_unit_tb: FAIL");
    end
    $finish;
  end
endmodule

// ===== matrix3_inverse_unit.f =====
+incdir+hdl
hdl/m3i_pkg.sv
hdl/m3i_div_lane.sv
hdl/m3i_front.sv
hdl/matrix3_inverse_unit.sv
tb/matrix3_inverse_unit_tb.sv
